// ===== rtl/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types and constants of the packed pixel reinterpret block: format
// codes, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    FMT_RGB565   = 2'd0,
    FMT_BGR565   = 2'd1,
    FMT_RGBA4444 = 2'd2,
    FMT_ARGB1555 = 2'd3
  } fmt_e;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_FORMAT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BIG_ENDIAN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DST_FORMAT     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DST_BIG_ENDIAN = CFG_IDX_W'(3);

  typedef struct packed {
    fmt_e src_format;
    logic src_big_endian;
    fmt_e dst_format;
    logic dst_big_endian;
  } ppr_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } pixel_t;

endpackage

// ===== rtl/packed_pixel_reinterpret_top.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_reinterpret_top
// Packs an RGBA8 pixel into a 16-bit word, swaps its bytes when the two byte
// orders differ and decodes it back to RGBA8 under a second format.
//
// Input channel: in_valid_i / in_stall_o with the four channel bytes. Output
// channel: out_valid_o / out_stall_i with the four decoded bytes. A word is
// taken at an edge where valid is high and stall is low.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Index 0 src_format, 1 src_big_endian, 2 dst_format,
// 3 dst_big_endian; higher indexes are ignored. Write only while idle.
// Path: the input register loads at the accepting edge, and the converted
// word moves on into the result register, which drives out_valid_o.
// Throughput: one pixel per cycle while the receiver does not stall.
// Reset: all config registers go to 0 (rgb565, little endian) and the
// pipeline empties. When the receiver stalls the result register holds, the
// input register fills, and then in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
module packed_pixel_reinterpret_top import ppr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      red_in_i,
  input  logic [PIX_W-1:0]      green_in_i,
  input  logic [PIX_W-1:0]      blue_in_i,
  input  logic [PIX_W-1:0]      alpha_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      red_out_o,
  output logic [PIX_W-1:0]      green_out_o,
  output logic [PIX_W-1:0]      blue_out_o,
  output logic [PIX_W-1:0]      alpha_out_o
);

  ppr_cfg_t cfg;
  pixel_t   in_pix;
  pixel_t   out_pix;

  assign in_pix = '{red: red_in_i, green: green_in_i, blue: blue_in_i, alpha: alpha_in_i};

  ppr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppr_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pix_i    (in_pix),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pix_o   (out_pix)
  );

  assign red_out_o   = out_pix.red;
  assign green_out_o = out_pix.green;
  assign blue_out_o  = out_pix.blue;
  assign alpha_out_o = out_pix.alpha;

endmodule

// ===== rtl/ppr_cfg.sv =====
// ----------------------------------------------------------------------------
// ppr_cfg
// Configuration register file: format and byte order of the packing and
// decoding sides, written through an indexed write port.
// ----------------------------------------------------------------------------
module ppr_cfg import ppr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output ppr_cfg_t              cfg_o
);

  ppr_cfg_t cfg_d, cfg_q;
  logic     wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        REG_SRC_FORMAT:     cfg_d.src_format     = fmt_e'(cfg_data_i[1:0]);
        REG_SRC_BIG_ENDIAN: cfg_d.src_big_endian = cfg_data_i[0];
        REG_DST_FORMAT:     cfg_d.dst_format     = fmt_e'(cfg_data_i[1:0]);
        REG_DST_BIG_ENDIAN: cfg_d.dst_big_endian = cfg_data_i[0];
        default: ; // writes past the last register are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{src_format: FMT_RGB565, src_big_endian: 1'b0,
                 dst_format: FMT_RGB565, dst_big_endian: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  a_hold_without_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(cfg_q))
    else $error("config changed without a write");

  a_out_of_range_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_index_i != REG_SRC_FORMAT && cfg_index_i != REG_SRC_BIG_ENDIAN &&
     cfg_index_i != REG_DST_FORMAT && cfg_index_i != REG_DST_BIG_ENDIAN) |=> $stable(cfg_q))
    else $error("write past the register list changed the config");

endmodule

// ===== rtl/ppr_conv.sv =====
// ----------------------------------------------------------------------------
// ppr_conv
// Pixel conversion logic: pack RGBA8 into a 16-bit word, swap its bytes when
// byte orders differ, and unpack it under the decoding format, replicating bits.
// ----------------------------------------------------------------------------
module ppr_conv import ppr_pkg::*; (
  input  ppr_cfg_t cfg_i,
  input  pixel_t   pix_i,
  output pixel_t   pix_o
);

  logic [WORD_W-1:0] packed_word;
  logic [WORD_W-1:0] dec_word;

  function automatic logic [PIX_W-1:0] rep4(input logic [3:0] v);
    rep4 = {v, v};
  endfunction

  function automatic logic [PIX_W-1:0] rep5(input logic [4:0] v);
    rep5 = {v, v[4:2]};
  endfunction

  function automatic logic [PIX_W-1:0] rep6(input logic [5:0] v);
    rep6 = {v, v[5:4]};
  endfunction

  always_comb begin
    case (cfg_i.src_format)
      FMT_RGB565:   packed_word = {pix_i.red[7:3], pix_i.green[7:2], pix_i.blue[7:3]};
      FMT_BGR565:   packed_word = {pix_i.blue[7:3], pix_i.green[7:2], pix_i.red[7:3]};
      FMT_RGBA4444: packed_word = {pix_i.red[7:4], pix_i.green[7:4],
                                   pix_i.blue[7:4], pix_i.alpha[7:4]};
      default:      packed_word = {pix_i.alpha[7], pix_i.red[7:3],
                                   pix_i.green[7:3], pix_i.blue[7:3]};
    endcase
  end

  // differing byte orders on the two sides amount to a byte swap
  assign dec_word = (cfg_i.src_big_endian ^ cfg_i.dst_big_endian)
                    ? {packed_word[7:0], packed_word[15:8]} : packed_word;

  always_comb begin
    case (cfg_i.dst_format)
      FMT_RGB565: begin
        pix_o.red   = rep5(dec_word[15:11]);
        pix_o.green = rep6(dec_word[10:5]);
        pix_o.blue  = rep5(dec_word[4:0]);
        pix_o.alpha = '1;
      end
      FMT_BGR565: begin
        pix_o.red   = rep5(dec_word[4:0]);
        pix_o.green = rep6(dec_word[10:5]);
        pix_o.blue  = rep5(dec_word[15:11]);
        pix_o.alpha = '1;
      end
      FMT_RGBA4444: begin
        pix_o.red   = rep4(dec_word[15:12]);
        pix_o.green = rep4(dec_word[11:8]);
        pix_o.blue  = rep4(dec_word[7:4]);
        pix_o.alpha = rep4(dec_word[3:0]);
      end
      default: begin
        pix_o.red   = rep5(dec_word[14:10]);
        pix_o.green = rep5(dec_word[9:5]);
        pix_o.blue  = rep5(dec_word[4:0]);
        pix_o.alpha = {PIX_W{dec_word[15]}};
      end
    endcase
  end

endmodule

// ===== rtl/ppr_pipe.sv =====
// ----------------------------------------------------------------------------
// ppr_pipe
// Two-register pipeline: input register, conversion logic, result register,
// with stall propagated back; one word moves per cycle unless out stalls.
// ----------------------------------------------------------------------------
module ppr_pipe import ppr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ppr_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pixel_t   in_pix_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pixel_t   out_pix_o
);

  logic   s1_valid_d, s1_valid_q;
  logic   s2_valid_d, s2_valid_q;
  pixel_t s1_pix_q;
  pixel_t s2_pix_q;
  pixel_t conv_pix;
  logic   s2_open;
  logic   s1_open;
  logic   in_take;
  logic   s2_load;

  ppr_conv u_conv (
    .cfg_i (cfg_i),
    .pix_i (s1_pix_q),
    .pix_o (conv_pix)
  );

  assign s2_open    = !s2_valid_q || !out_stall_i;
  assign s1_open    = !s1_valid_q || s2_open;
  assign in_stall_o = !s1_open;
  assign in_take    = in_valid_i && s1_open;
  assign s2_load    = s1_valid_q && s2_open;

  assign s1_valid_d = in_take || (s1_valid_q && !s2_open);
  assign s2_valid_d = s2_load || (s2_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_pix_q <= in_pix_i;
    end
    if (s2_load) begin
      s2_pix_q <= conv_pix;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_pix_o   = s2_pix_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_stall_i))
    else $error("input stalled while the pipeline had room");

  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted word did not land in the input register");

  a_advance_fills_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> s2_valid_q)
    else $error("converted word did not land in the result register");

  a_stalled_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && out_stall_i) |=> (s2_valid_q && $stable(s2_pix_q)))
    else $error("stalled result was lost or overwritten");

endmodule
